// ===== design/mlpq_pkg.sv =====
`default_nettype none
package mlpq_pkg;

   localparam int CAPACITY   = 64;
   localparam int TAG_BITS   = 32;
   localparam int NUM_LEVELS = 4;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int COUNT_W    = 7;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [2:0]  level;
      logic [31:0] patient_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_tag;
      logic [2:0]  out_level;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [SLOT_W-1:0] wr_data;
   } link_cmd_type;

   // Clamp the urgency field onto the four levels.
   function automatic logic [LEVEL_W-1:0] level_index(input logic [2:0] lvl);
      logic [LEVEL_W-1:0] idx;
      if (lvl <= 3'd1) begin
         idx = '0;
      end else if (lvl >= 3'd4) begin
         idx = LEVEL_W'(NUM_LEVELS - 1);
      end else begin
         idx = LEVEL_W'(lvl - 3'd1);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ===== design/mlpq_ram.sv =====
`default_nettype none
module mlpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/mlpq_link_store.sv =====
`default_nettype none
module mlpq_link_store (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mlpq_pkg::link_cmd_type      cmd,
   output logic [mlpq_pkg::SLOT_W-1:0]      rd_link
);

   logic [mlpq_pkg::CAPACITY-1:0] vld_ff;
   logic [mlpq_pkg::CAPACITY-1:0] vld_in;
   logic                          rd_vld_ff;
   logic [mlpq_pkg::SLOT_W-1:0]   rd_addr_ff;
   logic [mlpq_pkg::SLOT_W-1:0]   ram_q;
   logic [mlpq_pkg::SLOT_W-1:0]   dflt_link;

   mlpq_ram #(
      .WIDTH (mlpq_pkg::SLOT_W),
      .DEPTH (mlpq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (cmd.rd_en) begin
         rd_vld_ff  <= vld_ff[cmd.rd_addr];
         rd_addr_ff <= cmd.rd_addr;
      end
   end

   // Unwritten slot: free chain after reset, slot i links to i+1, last wraps to 0.
   assign dflt_link = (rd_addr_ff == mlpq_pkg::SLOT_W'(mlpq_pkg::CAPACITY - 1)) ?
                      '0 : rd_addr_ff + mlpq_pkg::SLOT_W'(1);
   assign rd_link   = rd_vld_ff ? ram_q : dflt_link;

endmodule
`default_nettype wire

// ===== design/multilevel_priority_queue.sv =====
`default_nettype none
// Four-level priority queue (level 4 most urgent, FIFO within a level) over a
// 64-slot pool. A request is accepted in S_IDLE, which reads the slot's link
// (and tag on dequeue) from the link and tag memories, whose read data is
// registered; S_DONE then updates heads, tails, free list and count, writes
// the link back and loads the response register. No new request is taken
// until S_DONE has finished the last one; a stalled response holds S_DONE.
// Every request yields exactly one response.
module multilevel_priority_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mlpq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mlpq_pkg::rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DONE = 2'b10
   } state_type;

   localparam int SW = mlpq_pkg::SLOT_W;
   localparam int LW = mlpq_pkg::LEVEL_W;
   localparam int NL = mlpq_pkg::NUM_LEVELS;

   state_type                   state_ff, state_in;
   logic                        deq_ff, deq_in;
   logic                        fail_ff, fail_in;
   logic [LW-1:0]               li_ff, li_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [SW-1:0]               head_ff [NL];
   logic [SW-1:0]               head_in [NL];
   logic [SW-1:0]               tail_ff [NL];
   logic [SW-1:0]               tail_in [NL];
   logic [NL-1:0]               nonempty_ff, nonempty_in;
   logic [SW-1:0]               free_head_ff, free_head_in;
   logic [mlpq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mlpq_pkg::rsp_type           rsp_ff, rsp_in;

   mlpq_pkg::link_cmd_type      link_cmd;
   logic [SW-1:0]               rd_link;
   logic                        tag_wr_en;
   logic                        tag_rd_en;
   logic [mlpq_pkg::TAG_BITS-1:0] tag_q;

   logic                        accept;
   logic                        finish;
   logic                        any_held;
   logic [LW-1:0]               top_li;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign finish    = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Pick the most urgent non-empty level.
   always_comb begin
      top_li   = '0;
      any_held = |nonempty_ff;
      for (int i = 0; i < NL; i++) begin
         if (nonempty_ff[i]) begin
            top_li = LW'(i);
         end
      end
   end

   mlpq_ram #(
      .WIDTH (mlpq_pkg::TAG_BITS),
      .DEPTH (mlpq_pkg::CAPACITY)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (free_head_ff),
      .wr_data (mlpq_pkg::TAG_BITS'(req_data.patient_tag)),
      .rd_en   (tag_rd_en),
      .rd_addr (head_ff[top_li]),
      .rd_data (tag_q)
   );

   mlpq_link_store u_link (
      .clock   (clock),
      .reset   (reset),
      .cmd     (link_cmd),
      .rd_link (rd_link)
   );

   always_comb begin
      state_in     = state_ff;
      deq_in       = deq_ff;
      fail_in      = fail_ff;
      li_in        = li_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_wr_en    = 1'b0;
      tag_rd_en    = 1'b0;
      link_cmd     = '0;

      if (accept) begin
         // Capture the request and start the memory reads.
         state_in = S_DONE;
         deq_in   = (req_data.op == mlpq_pkg::OP_DEQ);
         if (req_data.op == mlpq_pkg::OP_DEQ) begin
            fail_in          = !any_held;
            li_in            = top_li;
            slot_in          = head_ff[top_li];
            tag_rd_en        = any_held;
            link_cmd.rd_en   = any_held;
            link_cmd.rd_addr = head_ff[top_li];
         end else begin
            fail_in          = (count_ff == mlpq_pkg::COUNT_W'(mlpq_pkg::CAPACITY));
            li_in            = mlpq_pkg::level_index(req_data.level);
            slot_in          = free_head_ff;
            tag_wr_en        = !fail_in;
            link_cmd.rd_en   = !fail_in;
            link_cmd.rd_addr = free_head_ff;
         end
      end

      if (finish) begin
         // Commit the pointer updates and load the response.
         state_in              = S_IDLE;
         rsp_valid_in          = 1'b1;
         rsp_in.out_tag        = '0;
         rsp_in.out_level      = '0;
         if (fail_ff) begin
            rsp_in.status = deq_ff ? mlpq_pkg::ST_EMPTY : mlpq_pkg::ST_FULL;
         end else if (deq_ff) begin
            rsp_in.status    = mlpq_pkg::ST_OK;
            rsp_in.out_tag   = 32'(tag_q);
            rsp_in.out_level = 3'(li_ff) + 3'd1;
            if (slot_ff == tail_ff[li_ff]) begin
               nonempty_in[li_ff] = 1'b0;
            end else begin
               head_in[li_ff] = rd_link;
            end
            link_cmd.wr_en   = 1'b1;
            link_cmd.wr_addr = slot_ff;
            link_cmd.wr_data = free_head_ff;
            free_head_in     = slot_ff;
            count_in         = count_ff - mlpq_pkg::COUNT_W'(1);
         end else begin
            rsp_in.status = mlpq_pkg::ST_OK;
            free_head_in  = rd_link;
            if (nonempty_ff[li_ff]) begin
               // Append behind the current tail.
               link_cmd.wr_en   = 1'b1;
               link_cmd.wr_addr = tail_ff[li_ff];
               link_cmd.wr_data = slot_ff;
            end else begin
               head_in[li_ff]     = slot_ff;
               nonempty_in[li_ff] = 1'b1;
            end
            tail_in[li_ff] = slot_ff;
            count_in       = count_ff + mlpq_pkg::COUNT_W'(1);
         end
         rsp_in.entry_count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nonempty_ff  <= '0;
         free_head_ff <= '0;
         count_ff     <= '0;
         for (int i = 0; i < NL; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nonempty_ff  <= nonempty_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      deq_ff  <= deq_in;
      fail_ff <= fail_in;
      li_ff   <= li_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire
